>>> sv/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, command codes and controller command type for the
// double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W       = 3;
    localparam int OUT_W       = 32;
    localparam int COUNT_OUT_W = 11;
    localparam int FLAG_W      = 3;
    localparam int M_TDATA_W   = 112;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

    // Step strobes from the controller to the datapath
    typedef struct packed {
        logic load_in;   // capture the input transaction
        logic exec;      // update pointers, count, write the ring
        logic rd_issue;  // read new front and back from the ring
        logic out_load;  // move the result into the output register
    } deq_cmd_t;

endpackage

>>> sv/deq_ctrl.sv
// ----------------------------------------------------------------------------
// deq_ctrl
// Sequencer for one queue command: accept, execute, read back, load result.
// ----------------------------------------------------------------------------
module deq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output deq_pkg::deq_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_FILL = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    assign s_tready     = (state_reg == ST_IDLE);
    assign m_tvalid     = out_valid_reg;
    assign cmd.load_in  = s_tvalid && s_tready;
    assign cmd.exec     = (state_reg == ST_EXEC);
    assign cmd.rd_issue = (state_reg == ST_READ);
    assign cmd.out_load = (state_reg == ST_FILL) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load_in)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_READ;
            ST_READ: state_next = ST_FILL;
            ST_FILL:
            begin
                // hold until the output register is free
                if (cmd.out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> sv/deq_datapath.sv
// ----------------------------------------------------------------------------
// deq_datapath
// Ring memory, head/tail pointers, entry count and the result register.
// ----------------------------------------------------------------------------
module deq_datapath #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  deq_pkg::deq_cmd_t               cmd,
    input  logic [deq_pkg::CMD_W-1:0]       cmd_in,
    input  logic [deq_pkg::OUT_W-1:0]       data_in,
    output logic [deq_pkg::OUT_W-1:0]       popped_value,
    output logic                            pop_on_empty,
    output logic                            push_dropped,
    output logic [deq_pkg::COUNT_OUT_W-1:0] entry_count,
    output logic                            is_empty,
    output logic [deq_pkg::OUT_W-1:0]       front_value,
    output logic [deq_pkg::OUT_W-1:0]       back_value
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = deq_pkg::OUT_W;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [deq_pkg::CMD_W-1:0] cmd_reg;
    logic [DATA_WIDTH-1:0]     data_reg;
    logic [AW-1:0]             head_reg, head_next;
    logic [AW-1:0]             tail_reg, tail_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [DATA_WIDTH-1:0]     rd_front_reg;
    logic [DATA_WIDTH-1:0]     rd_back_reg;
    logic [OW-1:0]             popped_reg, popped_next;
    logic                      pop_empty_reg, pop_empty_next;
    logic                      dropped_reg, dropped_next;
    logic                      wr_en;
    logic [AW-1:0]             wr_addr;
    logic [AW-1:0]             head_dec, head_inc, tail_dec, tail_inc;
    logic                      full, empty;
    logic [OW-1:0]             front_ext, back_ext;

    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;

    assign full  = (count_reg == FULL_CNT);
    assign empty = (count_reg == '0);

    // sign-extend from the stored width, keep the low 32 bits
    assign front_ext = OW'($signed(rd_front_reg));
    assign back_ext  = OW'($signed(rd_back_reg));

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        popped_next    = '0;
        pop_empty_next = 1'b0;
        dropped_next   = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = tail_reg;
        case (cmd_reg)
            deq_pkg::CMD_PUSH_FRONT:
            begin
                if (full)
                begin
                    dropped_next = 1'b1;
                end
                else
                begin
                    head_next  = head_dec;
                    wr_addr    = head_dec;
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    dropped_next = 1'b1;
                end
                else
                begin
                    tail_next  = tail_inc;
                    wr_addr    = tail_reg;
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            deq_pkg::CMD_POP_FRONT:
            begin
                if (empty)
                begin
                    popped_next    = '1;
                    pop_empty_next = 1'b1;
                end
                else
                begin
                    popped_next = front_ext;
                    head_next   = head_inc;
                    count_next  = count_reg - 1'b1;
                end
            end
            deq_pkg::CMD_POP_BACK:
            begin
                if (empty)
                begin
                    popped_next    = '1;
                    pop_empty_next = 1'b1;
                end
                else
                begin
                    popped_next = back_ext;
                    tail_next   = tail_dec;
                    count_next  = count_reg - 1'b1;
                end
            end
            default:
            begin
                // query and unused codes change nothing
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg  <= cmd_in;
            data_reg <= DATA_WIDTH'(data_in);
        end
        if (cmd.exec)
        begin
            popped_reg    <= popped_next;
            pop_empty_reg <= pop_empty_next;
            dropped_reg   <= dropped_next;
        end
        if (cmd.out_load)
        begin
            popped_value <= popped_reg;
            pop_on_empty <= pop_empty_reg;
            push_dropped <= dropped_reg;
            entry_count  <= deq_pkg::COUNT_OUT_W'(count_reg);
            is_empty     <= empty;
            front_value  <= empty ? '1 : front_ext;
            back_value   <= empty ? '1 : back_ext;
        end
    end

    // Ring memory: one write port, two registered read ports. The read
    // registers double as the current front and back until the next read.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && wr_en)
        begin
            mem[wr_addr] <= data_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_front_reg <= mem[head_reg];
            rd_back_reg  <= mem[tail_dec];
        end
    end

endmodule

>>> sv/double_ended_queue.sv
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded double-ended queue on a ring memory, one result per command.
// ----------------------------------------------------------------------------
// Each command passes four controller steps: accept, update pointers and
// write the ring, read the new front and back entries through the two read
// ports of the ring memory, load the output register. The block takes a new
// command only after the previous one has loaded its result into the output
// register; the read-back of the ring after every update keeps it busy until
// then. A result waiting in the output register does not block the next
// command; the result of that command then holds in the controller, with the
// input held off, until the first is taken. Pushes on a full queue are
// dropped and flagged, pops on an empty queue return -1 and are flagged.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // data_value[31:0]
    input  logic [deq_pkg::OUT_W-1:0]       s_axis_tdata,
    // cmd[2:0]
    input  logic [deq_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // popped_value[31:0], entry_count[42:32], front_value[74:43],
    // back_value[106:75], zero pad[111:107]
    output logic [deq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // pop_on_empty[0], push_dropped[1], is_empty[2]
    output logic [deq_pkg::FLAG_W-1:0]      m_axis_tuser
);

    localparam int PAD_W = deq_pkg::M_TDATA_W - 3 * deq_pkg::OUT_W
                           - deq_pkg::COUNT_OUT_W;

    deq_pkg::deq_cmd_t               cmd;
    logic [deq_pkg::OUT_W-1:0]       popped_value;
    logic                            pop_on_empty;
    logic                            push_dropped;
    logic [deq_pkg::COUNT_OUT_W-1:0] entry_count;
    logic                            is_empty;
    logic [deq_pkg::OUT_W-1:0]       front_value;
    logic [deq_pkg::OUT_W-1:0]       back_value;

    deq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .cmd      (cmd)
    );

    deq_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cmd_in       (s_axis_tuser),
        .data_in      (s_axis_tdata),
        .popped_value (popped_value),
        .pop_on_empty (pop_on_empty),
        .push_dropped (push_dropped),
        .entry_count  (entry_count),
        .is_empty     (is_empty),
        .front_value  (front_value),
        .back_value   (back_value)
    );

    assign m_axis_tdata = {{PAD_W{1'b0}}, back_value, front_value, entry_count, popped_value};
    assign m_axis_tuser = {is_empty, push_dropped, pop_on_empty};

endmodule

>>> sv/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_port_checker
// Port-level checks for the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_port_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one command in flight: no acceptance in the cycle after one
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted on consecutive cycles");

    // an empty pop reports -1
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[31:0] == 32'hFFFF_FFFF)
        else $error("empty pop without -1");

    // an empty queue shows zero count and -1 at both ends
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            m_axis_tdata[42:32] == 11'd0 && m_axis_tdata[74:43] == 32'hFFFF_FFFF
            && m_axis_tdata[106:75] == 32'hFFFF_FFFF)
        else $error("empty flag with inconsistent fields");

    // a transaction is a pop or a push, never both failed
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("both pop and push failure flagged");

endmodule

bind double_ended_queue deq_port_checker u_port_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> test/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Watches both stream channels of the double-ended queue, keeps its own ring,
// pointers and count, predicts one result per accepted command and compares
// every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module deq_checker #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    // data_value[31:0]
    input  logic [deq_pkg::OUT_W-1:0]       s_axis_tdata,
    // cmd[2:0]
    input  logic [deq_pkg::CMD_W-1:0]       s_axis_tuser,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // popped_value[31:0], entry_count[42:32], front_value[74:43],
    // back_value[106:75], zero pad[111:107]
    input  logic [deq_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // pop_on_empty[0], push_dropped[1], is_empty[2]
    input  logic [deq_pkg::FLAG_W-1:0]      m_axis_tuser,
    output int                              fail_count,
    output int                              results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [deq_pkg::OUT_W-1:0]       popped_value;
        logic                            pop_on_empty;
        logic                            push_dropped;
        logic [deq_pkg::COUNT_OUT_W-1:0] entry_count;
        logic                            is_empty;
        logic [deq_pkg::OUT_W-1:0]       front_value;
        logic [deq_pkg::OUT_W-1:0]       back_value;
    } deq_result_t;

    logic [DATA_WIDTH-1:0] ring_copy [DEPTH];
    int unsigned           head_slot;
    int unsigned           tail_slot;
    int unsigned           occupancy;
    deq_result_t           expected_results [$];
    int                    mismatches = 0;

    assign fail_count      = mismatches;
    assign results_pending = expected_results.size();

    function automatic int unsigned slot_next(input int unsigned i);
        return (i + 1) % DEPTH;
    endfunction

    function automatic int unsigned slot_prev(input int unsigned i);
        return (i + DEPTH - 1) % DEPTH;
    endfunction

    // sign-extend a stored entry to the 32-bit result field
    function automatic logic [deq_pkg::OUT_W-1:0] widen(input logic [DATA_WIDTH-1:0] v);
        logic [63:0] w;
        w = 64'($signed(v));
        return w[deq_pkg::OUT_W-1:0];
    endfunction

    task automatic apply_command(input logic [deq_pkg::CMD_W-1:0] c,
                                 input logic [deq_pkg::OUT_W-1:0] v,
                                 output deq_result_t r);
        logic full;
        r    = '0;
        full = (occupancy >= DEPTH);
        case (c)
            deq_pkg::CMD_PUSH_FRONT:
                if (full)
                    r.push_dropped = 1'b1;
                else
                begin
                    head_slot            = slot_prev(head_slot);
                    ring_copy[head_slot] = v[DATA_WIDTH-1:0];
                    occupancy++;
                end
            deq_pkg::CMD_PUSH_BACK:
                if (full)
                    r.push_dropped = 1'b1;
                else
                begin
                    ring_copy[tail_slot] = v[DATA_WIDTH-1:0];
                    tail_slot            = slot_next(tail_slot);
                    occupancy++;
                end
            deq_pkg::CMD_POP_FRONT:
                if (occupancy == 0)
                begin
                    r.popped_value = '1;
                    r.pop_on_empty = 1'b1;
                end
                else
                begin
                    r.popped_value = widen(ring_copy[head_slot]);
                    head_slot      = slot_next(head_slot);
                    occupancy--;
                end
            deq_pkg::CMD_POP_BACK:
                if (occupancy == 0)
                begin
                    r.popped_value = '1;
                    r.pop_on_empty = 1'b1;
                end
                else
                begin
                    tail_slot      = slot_prev(tail_slot);
                    r.popped_value = widen(ring_copy[tail_slot]);
                    occupancy--;
                end
            default:
                ;  // query and the spare codes change nothing
        endcase
        r.entry_count = occupancy[deq_pkg::COUNT_OUT_W-1:0];
        if (occupancy == 0)
        begin
            r.is_empty    = 1'b1;
            r.front_value = '1;
            r.back_value  = '1;
        end
        else
        begin
            r.front_value = widen(ring_copy[head_slot]);
            r.back_value  = widen(ring_copy[slot_prev(tail_slot)]);
        end
    endtask

    task automatic check_field(input string name, input logic [deq_pkg::OUT_W-1:0] want,
                               input logic [deq_pkg::OUT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        deq_result_t want;
        deq_result_t fresh;
        if (!rst_n)
        begin
            head_slot = 0;
            tail_slot = 0;
            occupancy = 0;
            expected_results.delete();
        end
        else
        begin
            // results first: a command accepted now cannot have its result out yet
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result transaction with no command waiting for it");
                    mismatches++;
                end
                else
                begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    check_field("popped_value", want.popped_value, m_axis_tdata[31:0]);
                    check_field("entry_count", 32'(want.entry_count), 32'(m_axis_tdata[42:32]));
                    check_field("front_value", want.front_value, m_axis_tdata[74:43]);
                    check_field("back_value", want.back_value, m_axis_tdata[106:75]);
                    check_field("zero_pad", 32'd0, 32'(m_axis_tdata[111:107]));
                    check_field("pop_on_empty", 32'(want.pop_on_empty), 32'(m_axis_tuser[0]));
                    check_field("push_dropped", 32'(want.push_dropped), 32'(m_axis_tuser[1]));
                    check_field("is_empty", 32'(want.is_empty), 32'(m_axis_tuser[2]));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_command(s_axis_tuser, s_axis_tdata, fresh);
                expected_results = {expected_results, fresh};
            end
        end
    end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the double-ended queue: directed corner commands,
// random mixed traffic, a fill to capacity with pushes on the full queue, and
// a partial drain, with random idling on both channels and one long receiver
// hold-off. Prediction and comparison live in deq_checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = deq_pkg::DEPTH_DEF;
    localparam int STALL_CYCLES = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int IDLE_PCT     = 22;

    localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
    localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_MID = 3'd6;
    localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [deq_pkg::OUT_W-1:0]     s_axis_tdata = '0;
    logic [deq_pkg::CMD_W-1:0]     s_axis_tuser = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [deq_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [deq_pkg::FLAG_W-1:0]    m_axis_tuser;
    int                            fail_count;
    int                            results_pending;

    bit                            idle_on = 1'b1;
    bit                            stall_request = 1'b0;
    bit                            stall_served = 1'b0;
    int                            fill_level = 0;

    always #2 clk = ~clk;

    double_ended_queue dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    deq_checker checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    // Offer one command and hold it until the transaction completes.
    task automatic send_item(input logic [deq_pkg::CMD_W-1:0] c,
                             input logic [deq_pkg::OUT_W-1:0] v);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= c;
        s_axis_tdata  <= v;
        do
            @(posedge clk);
        while (!s_axis_tready);
        // track occupancy only, to steer the fill and drain phases
        if ((c == deq_pkg::CMD_PUSH_FRONT || c == deq_pkg::CMD_PUSH_BACK) && fill_level < DEPTH)
            fill_level++;
        else if ((c == deq_pkg::CMD_POP_FRONT || c == deq_pkg::CMD_POP_BACK) && fill_level > 0)
            fill_level--;
    endtask

    function automatic logic [deq_pkg::OUT_W-1:0] pick_value();
        case ($urandom_range(15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [deq_pkg::CMD_W-1:0] pick_push();
        return $urandom_range(1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
    endfunction

    function automatic logic [deq_pkg::CMD_W-1:0] pick_pop();
        return $urandom_range(1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
    endfunction

    function automatic logic [deq_pkg::CMD_W-1:0] CMD_CMD_SPARE();
        return deq_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    endfunction

    function automatic logic [deq_pkg::CMD_W-1:0] pick_mixed();
        case ($urandom_range(9))
            0, 1, 2, 3: return pick_push();
            4, 5, 6, 7: return pick_pop();
            8:          return deq_pkg::CMD_QUERY;
            default:    return CMD_CMD_SPARE();
        endcase
    endfunction

    // receiver: random back-pressure, plus one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_request && !stall_served)
            begin
                stall_served = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(posedge clk);
            end
            else if (rst_n)
                m_axis_tready <= idle_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
        end
    end

    // watchdog: end the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("double_ended_queue test failed");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pops, query, spare codes, extremes at both ends
        send_item(deq_pkg::CMD_QUERY, 32'h1234_5678);
        send_item(deq_pkg::CMD_POP_FRONT, 32'h0);
        send_item(deq_pkg::CMD_POP_BACK, 32'hFFFF_FFFF);
        send_item(CMD_SPARE_LO, 32'hDEAD_BEEF);
        send_item(CMD_SPARE_MID, 32'h0);
        send_item(CMD_SPARE_HI, 32'hFFFF_FFFF);
        send_item(deq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
        send_item(deq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
        send_item(deq_pkg::CMD_PUSH_BACK, 32'h0000_0000);
        send_item(deq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
        send_item(deq_pkg::CMD_QUERY, 32'h0);
        send_item(deq_pkg::CMD_POP_FRONT, 32'h0);
        send_item(deq_pkg::CMD_POP_BACK, 32'h0);
        send_item(deq_pkg::CMD_POP_FRONT, 32'h0);
        send_item(deq_pkg::CMD_POP_BACK, 32'h0);
        send_item(deq_pkg::CMD_POP_FRONT, 32'h0);
        send_item(deq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
        send_item(deq_pkg::CMD_PUSH_BACK, 32'h5555_5555);
        send_item(deq_pkg::CMD_POP_BACK, 32'h0);
        send_item(deq_pkg::CMD_POP_BACK, 32'h0);
        send_item(deq_pkg::CMD_POP_BACK, 32'h0);
        send_item(deq_pkg::CMD_PUSH_BACK, 32'h0000_0001);
        send_item(CMD_SPARE_LO, 32'hFFFF_FFFF);
        send_item(deq_pkg::CMD_POP_FRONT, 32'h0);

        // random mixed traffic near empty, with a stretch of no idling
        for (int i = 0; i < 150; i++)
        begin
            idle_on = !(i >= 50 && i < 110);
            send_item(pick_mixed(), pick_value());
        end
        idle_on = 1'b1;

        // fill to capacity, mostly pushes; the long hold-off backs up the input
        stall_request = 1'b1;
        while (fill_level < DEPTH)
            send_item(($urandom_range(99) < 95) ? pick_push() : pick_mixed(), pick_value());

        // at capacity: dropped pushes, queries, pop and refill
        for (int i = 0; i < 30; i++)
        begin
            if (fill_level < DEPTH)
                send_item(pick_push(), pick_value());
            else
                send_item(($urandom_range(99) < 70) ? pick_push() : pick_mixed(), pick_value());
        end

        // partial drain, mostly pops
        for (int i = 0; i < 100; i++)
            send_item(($urandom_range(99) < 80) ? pick_pop() : pick_mixed(), pick_value());

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (results_pending == 0);
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("double_ended_queue test passed");
        else
            $display("double_ended_queue test failed");
        $finish;
    end

endmodule
